// ===== src/deque_with_search_macros.svh =====
// assertion macros used by the deque datapath dqs_dp
// no dependencies; include with the bare file name
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

// same-cycle implication, disabled in reset
`define DQS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// next-cycle implication, disabled in reset
`define DQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

// ===== src/dqs_pkg.sv =====
// types and constants of the deque with search
// no dependencies
package dqs_pkg;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic scan_done;
  } dqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic search_wait;
    logic hit;
    logic last;
  } dqs_sts_t;

endpackage

// ===== src/dqs_in_if.sv =====
// input channel of the deque: operation beat
// depends on dqs_pkg
interface dqs_in_if;
  import dqs_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

// ===== src/dqs_out_if.sv =====
// result channel of the deque: status beat
// depends on dqs_pkg
interface dqs_out_if;
  import dqs_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output found, output count, input ready);
  modport sink   (input valid, input status, input found, input count, output ready);
endinterface

// ===== src/deque_with_search.sv =====
// Bounded double-ended queue of signed 32-bit values with a linear search. Push front, push
// back, pop front and pop back can follow one another every cycle while results are taken.
// A search reads the held entries from front to back through the registered read port of
// the entry ram, one entry a cycle, and ends early on a match; no item is accepted meanwhile.
// Each operation returns one result beat with status, found flag and entry count. The ram
// needs no clearing pass after reset: only held entries are ever read.
//
// top level; depends on dqs_pkg, dqs_in_if, dqs_out_if, dqs_ctrl, dqs_dp
module deque_with_search #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  dqs_in_if.sink      in_bus,
  dqs_out_if.source   out_bus
);
  import dqs_pkg::*;

  dqs_cmd_t cmd;
  dqs_sts_t sts;

  dqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (in_bus.func),
    .in_value   (in_bus.value),
    .out_ready  (out_bus.ready),
    .out_valid  (out_bus.valid),
    .out_status (out_bus.status),
    .out_found  (out_bus.found),
    .out_count  (out_bus.count)
  );

endmodule

// ===== src/dqs_ram.sv =====
// generic simple dual-port ram, one write and one registered read
// no dependencies
module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dqs_ctrl.sv =====
// controller of the deque: idle / scan state machine
// depends on dqs_pkg
module dqs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dqs_pkg::dqs_sts_t sts,
  output dqs_pkg::dqs_cmd_t cmd
);
  import dqs_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.accept = 1'b1;
          if (sts.search_wait) begin
            cmd.scan_start = 1'b1;
            state_nxt      = FSM_SCAN;
          end
        end
      end
      FSM_SCAN: begin
        if (sts.hit || sts.last) begin
          cmd.scan_done = 1'b1;
          state_nxt     = FSM_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

endmodule

// ===== src/dqs_dp.sv =====
// datapath of the deque: ring pointers, entry ram, scan pointer, result register
// depends on dqs_pkg, dqs_ram and deque_with_search_macros.svh
`include "deque_with_search_macros.svh"

module dqs_dp #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dqs_pkg::dqs_cmd_t              cmd,
  output dqs_pkg::dqs_sts_t              sts,
  input  logic [dqs_pkg::FUNC_W-1:0]     in_func,
  input  logic [dqs_pkg::VALUE_W-1:0]    in_value,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [dqs_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_found,
  output logic [dqs_pkg::COUNT_W-1:0]    out_count
);
  import dqs_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [AW-1:0]    front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic             res_found_r, res_found_nxt;
  logic [COUNT_W-1:0]  res_count_r, res_count_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [VALUE_W-1:0] rdata;

  logic             full;
  logic             empty;
  logic             out_free;
  logic             load;
  logic [AW-1:0]    front_inc;
  logic [AW-1:0]    front_dec;
  logic [AW-1:0]    ptr_inc;
  logic [AW:0]      back_sum;
  logic [AW-1:0]    back_pos;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign out_free  = !out_valid_r || out_ready;
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  assign ptr_inc   = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  // front plus count, wrapped once around the ring
  assign back_sum  = {1'b0, front_r} + (AW + 1)'(count_r);
  assign back_pos  = (back_sum >= (AW + 1)'(DEPTH)) ?
                     AW'(back_sum - (AW + 1)'(DEPTH)) : back_sum[AW-1:0];
  assign raddr     = cmd.scan_start ? front_r : ptr_r;

  assign sts.out_free    = out_free;
  assign sts.search_wait = (in_func == OP_SEARCH) && !empty;
  assign sts.hit         = (rdata == key_r);
  assign sts.last        = last_r;

  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    ptr_nxt        = ptr_r;
    left_nxt       = left_r;
    last_nxt       = last_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    we             = 1'b0;
    waddr          = back_pos;
    load           = 1'b0;

    if (cmd.scan_start) begin
      // first read goes out now, the rest follow one a cycle
      key_nxt  = in_value;
      ptr_nxt  = front_inc;
      left_nxt = count_r - 1'b1;
      last_nxt = (count_r == CNT_W'(1));
    end else if (cmd.accept) begin
      load           = 1'b1;
      res_status_nxt = STS_OK;
      res_found_nxt  = 1'b0;
      case (in_func)
        OP_PUSH_FRONT: begin
          if (full) begin
            res_status_nxt = STS_FULL;
          end else begin
            we        = 1'b1;
            waddr     = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            res_status_nxt = STS_FULL;
          end else begin
            we        = 1'b1;
            waddr     = back_pos;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res_status_nxt = STS_EMPTY;
          end else begin
            front_nxt = front_inc;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            res_status_nxt = STS_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (cmd.scan_step && (left_r != '0)) begin
      ptr_nxt  = ptr_inc;
      left_nxt = left_r - 1'b1;
      last_nxt = (left_r == CNT_W'(1));
    end

    if (cmd.scan_done) begin
      load           = 1'b1;
      res_status_nxt = STS_OK;
      res_found_nxt  = sts.hit;
    end
  end

  assign cnt_ext       = (CNT_W + COUNT_W)'(count_nxt);
  assign res_count_nxt = load ? cnt_ext[COUNT_W-1:0] : res_count_r;
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      left_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    ptr_r        <= ptr_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_count_r  <= res_count_nxt;
  end

  dqs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_status = res_status_r;
  assign out_found  = res_found_r;
  assign out_count  = res_count_r;

  `DQS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `DQS_ASSERT_NOW(a_load_free, clk, rst_n, load, !out_valid_r || out_ready)
  `DQS_ASSERT_NEXT(a_done_result, clk, rst_n, cmd.scan_done, out_valid_r)
  `DQS_ASSERT_NEXT(a_count_hold, clk, rst_n, !cmd.accept, $stable(count_r))

endmodule
